>>> design/g2l_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package g2l_pkg;

	localparam int YEAR_COUNT = 201;
	localparam int FIRST_YEAR = 1900;
	localparam int EPOCH_DAY  = 31;
	localparam int EPOCH_SKIP = EPOCH_DAY - 1;
	// century years inside the table range that are not gregorian leap years
	localparam int NOLEAP_CENT_A = 1900;
	localparam int NOLEAP_CENT_B = 2100;

	localparam int ACC_W = 17;
	localparam int YIDX_W = 8;
	localparam int UPC_W = 4;

	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [YIDX_W-1:0] yidx_t;
	typedef logic [UPC_W-1:0]  upc_t;
	typedef logic [16:0]       desc_t;

	// datapath operations
	typedef logic [3:0] op_t;
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_LOAD     = 4'd1;
	localparam op_t OP_YMUL     = 4'd2;
	localparam op_t OP_DAYS     = 4'd3;
	localparam op_t OP_EPOCH    = 4'd4;
	localparam op_t OP_YSTEP    = 4'd5;
	localparam op_t OP_MINIT    = 4'd6;
	localparam op_t OP_MSTEP    = 4'd7;
	localparam op_t OP_EMIT_OK  = 4'd8;
	localparam op_t OP_EMIT_BAD = 4'd9;

	// jump conditions
	typedef logic [3:0] cond_t;
	localparam cond_t C_NONE   = 4'd0;
	localparam cond_t C_ALWAYS = 4'd1;
	localparam cond_t C_IN     = 4'd2;
	localparam cond_t C_BAD    = 4'd3;
	localparam cond_t C_EARLY  = 4'd4;
	localparam cond_t C_YDONE  = 4'd5;
	localparam cond_t C_YEND   = 4'd6;
	localparam cond_t C_MDONE  = 4'd7;
	localparam cond_t C_MISS   = 4'd8;
	localparam cond_t C_OFREE  = 4'd9;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
		logic  stay;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic bad;
		logic early;
		logic yfit;
		logic ylast;
		logic yend;
		logic mfit;
		logic mlast;
		logic hit;
		logic out_free;
	} flags_t;

	typedef struct packed {
		logic [11:0] greg_year;
		logic [3:0]  greg_month;
		logic [4:0]  greg_day;
	} in_word_t;

	typedef struct packed {
		logic        date_valid;
		logic [11:0] lunar_year;
		logic [3:0]  lunar_month;
		logic [4:0]  lunar_day;
		logic        leap_month_flag;
	} out_word_t;

	// bit 16 leap month long, bits 15..4 months 1..12 long, bits 3..0 leap month
	localparam desc_t YEAR_ROM [YEAR_COUNT] = '{
		17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554,
		17'h056a0, 17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250,
		17'h1d255, 17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970,
		17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570,
		17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0, 17'h0ea50, 17'h06e95, 17'h05ad0,
		17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950, 17'h0d4a0, 17'h1d8a6,
		17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950,
		17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5d0, 17'h14573,
		17'h052d0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60,
		17'h0aae4, 17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
		17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558,
		17'h0b540, 17'h0b6a0, 17'h195a6, 17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0,
		17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570, 17'h04af5,
		17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58, 17'h05ac0, 17'h0ab60,
		17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
		17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
		17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0,
		17'h0a930, 17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6,
		17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0,
		17'h04bd7, 17'h04ad0, 17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
		17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577, 17'h0a4b0, 17'h0aa50,
		17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370, 17'h049f8, 17'h04970,
		17'h064b0, 17'h168a6, 17'h0ea50, 17'h06aa0, 17'h1a6c4, 17'h0aae0, 17'h0a2e0,
		17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
		17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6,
		17'h0ad50, 17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930,
		17'h07337, 17'h06aa0, 17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4,
		17'h0d160, 17'h0e968, 17'h0d520, 17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0,
		17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252, 17'h0d520
	};

	function automatic desc_t year_desc(input yidx_t idx);
		desc_t d;
		d = '0;
		if (int'(idx) < YEAR_COUNT) begin
			d = YEAR_ROM[idx];
		end
		return d;
	endfunction

	// lunar year length; a function of the index only, so it folds into a table
	function automatic logic [8:0] year_len(input yidx_t idx);
		desc_t      d;
		logic [8:0] n;
		d = year_desc(idx);
		n = 9'd348;
		for (int b = 4; b < 16; b++) begin
			n = n + 9'(d[b]);
		end
		if (d[3:0] != 4'd0) begin
			n = n + (d[16] ? 9'd30 : 9'd29);
		end
		return n;
	endfunction

	function automatic logic [4:0] greg_mdays(input logic [3:0] m, input logic lp);
		logic [4:0] r;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd2: r = lp ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// days before the first of month m in a common year
	function automatic logic [8:0] month_prefix(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd2:  r = 9'd31;
			4'd3:  r = 9'd59;
			4'd4:  r = 9'd90;
			4'd5:  r = 9'd120;
			4'd6:  r = 9'd151;
			4'd7:  r = 9'd181;
			4'd8:  r = 9'd212;
			4'd9:  r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			4'd12: r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/g2l_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface g2l_in_if;
	logic               valid;
	logic               ready;
	g2l_pkg::in_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/g2l_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface g2l_out_if;
	logic               valid;
	logic               ready;
	g2l_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/g2l_useq.sv
`timescale 1ns / 1ps
`default_nettype none
module g2l_useq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  g2l_pkg::flags_t      flags,
	output g2l_pkg::ctl_t        ctl
);

	localparam g2l_pkg::upc_t P_IDLE  = 4'd0;
	localparam g2l_pkg::upc_t P_CHECK = 4'd1;
	localparam g2l_pkg::upc_t P_YMUL  = 4'd2;
	localparam g2l_pkg::upc_t P_DAYS  = 4'd3;
	localparam g2l_pkg::upc_t P_EPOCH = 4'd4;
	localparam g2l_pkg::upc_t P_YWALK = 4'd5;
	localparam g2l_pkg::upc_t P_YEXIT = 4'd6;
	localparam g2l_pkg::upc_t P_MWALK = 4'd7;
	localparam g2l_pkg::upc_t P_MEXIT = 4'd8;
	localparam g2l_pkg::upc_t P_OK    = 4'd9;
	localparam g2l_pkg::upc_t P_FAIL  = 4'd10;

	function automatic g2l_pkg::ctl_t uword(input g2l_pkg::upc_t a);
		g2l_pkg::ctl_t w;
		unique case (a)
			P_IDLE:  w = '{g2l_pkg::OP_LOAD, g2l_pkg::C_IN, P_CHECK, 1'b1};
			P_CHECK: w = '{g2l_pkg::OP_NOP, g2l_pkg::C_BAD, P_FAIL, 1'b0};
			P_YMUL:  w = '{g2l_pkg::OP_YMUL, g2l_pkg::C_NONE, P_IDLE, 1'b0};
			P_DAYS:  w = '{g2l_pkg::OP_DAYS, g2l_pkg::C_NONE, P_IDLE, 1'b0};
			P_EPOCH: w = '{g2l_pkg::OP_EPOCH, g2l_pkg::C_EARLY, P_FAIL, 1'b0};
			P_YWALK: w = '{g2l_pkg::OP_YSTEP, g2l_pkg::C_YDONE, P_YEXIT, 1'b1};
			P_YEXIT: w = '{g2l_pkg::OP_MINIT, g2l_pkg::C_YEND, P_FAIL, 1'b0};
			P_MWALK: w = '{g2l_pkg::OP_MSTEP, g2l_pkg::C_MDONE, P_MEXIT, 1'b1};
			P_MEXIT: w = '{g2l_pkg::OP_NOP, g2l_pkg::C_MISS, P_FAIL, 1'b0};
			P_OK:    w = '{g2l_pkg::OP_EMIT_OK, g2l_pkg::C_OFREE, P_IDLE, 1'b1};
			P_FAIL:  w = '{g2l_pkg::OP_EMIT_BAD, g2l_pkg::C_OFREE, P_IDLE, 1'b1};
			default: w = '{g2l_pkg::OP_NOP, g2l_pkg::C_ALWAYS, P_IDLE, 1'b0};
		endcase
		return w;
	endfunction

	g2l_pkg::upc_t pc_q;
	g2l_pkg::upc_t pc_next;
	logic          taken;

	assign ctl = uword(pc_q);

	always_comb begin
		unique case (ctl.cond)
			g2l_pkg::C_NONE:   taken = 1'b0;
			g2l_pkg::C_ALWAYS: taken = 1'b1;
			g2l_pkg::C_IN:     taken = flags.in_valid;
			g2l_pkg::C_BAD:    taken = flags.bad;
			g2l_pkg::C_EARLY:  taken = flags.early;
			g2l_pkg::C_YDONE:  taken = flags.yfit || flags.ylast;
			g2l_pkg::C_YEND:   taken = flags.yend;
			g2l_pkg::C_MDONE:  taken = flags.mfit || flags.mlast;
			g2l_pkg::C_MISS:   taken = !flags.hit;
			g2l_pkg::C_OFREE:  taken = flags.out_free;
			default:           taken = 1'b0;
		endcase
	end

	always_comb begin
		priority if (taken) begin
			pc_next = ctl.target;
		end else if (ctl.stay) begin
			pc_next = pc_q;
		end else begin
			pc_next = pc_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

`ifndef SYNTHESIS
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= P_FAIL)
		else $error("sequencer left its program");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == P_IDLE && flags.in_valid) |=> pc_q == P_CHECK)
		else $error("accepted word did not start the program");

	a_ywalk: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == P_YWALK |=> (pc_q == P_YWALK || pc_q == P_YEXIT))
		else $error("year walk left by a wrong path");
`endif

endmodule
`default_nettype wire

>>> design/g2l_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module g2l_dpath (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  g2l_pkg::ctl_t    ctl,
	output g2l_pkg::flags_t  flags,
	g2l_in_if.sink           req,
	g2l_out_if.source        rsp
);

	logic [11:0]         gy_q;
	logic [3:0]          gm_q;
	logic [4:0]          gd_q;
	g2l_pkg::acc_t       acc_q;
	g2l_pkg::yidx_t      yr_q;
	logic [3:0]          mon_q;
	logic                phase_q;
	logic                hit_q;
	g2l_pkg::desc_t      info_q;
	g2l_pkg::out_word_t  out_q;
	logic                out_valid_q;

	logic                g_leap;
	logic                in_range;
	logic [4:0]          mdays;
	logic                bad;
	g2l_pkg::yidx_t      yoff;
	logic [5:0]          leapcnt;
	logic                feb_adj;
	g2l_pkg::acc_t       day_sum;
	logic [8:0]          ylen;
	logic                yfit;
	logic [4:0]          mbit_idx;
	logic [4:0]          mlen;
	logic                mfit;
	logic                mlast;
	logic                out_free;
	logic                emit;

	assign in_range = (gy_q >= 12'(g2l_pkg::FIRST_YEAR))
		&& (gy_q < 12'(g2l_pkg::FIRST_YEAR + g2l_pkg::YEAR_COUNT));
	// within the table range only two century years need the exception
	assign g_leap = (gy_q[1:0] == 2'd0) && (gy_q != 12'(g2l_pkg::NOLEAP_CENT_A))
		&& (gy_q != 12'(g2l_pkg::NOLEAP_CENT_B));
	assign mdays = g2l_pkg::greg_mdays(gm_q, g_leap);
	assign bad = !in_range || (mdays == 5'd0) || (gd_q == 5'd0) || (gd_q > mdays);

	assign yoff = g2l_pkg::YIDX_W'(gy_q - 12'(g2l_pkg::FIRST_YEAR));
	// leap years from the base year up to the year before
	assign leapcnt = (yoff == '0) ? 6'd0 : 6'((yoff - 8'd1) >> 2);
	assign feb_adj = g_leap && (gm_q > 4'd2);
	assign day_sum = acc_q + g2l_pkg::ACC_W'(leapcnt)
		+ g2l_pkg::ACC_W'(g2l_pkg::month_prefix(gm_q))
		+ g2l_pkg::ACC_W'(feb_adj) + g2l_pkg::ACC_W'(gd_q) - 17'd1;

	assign ylen = g2l_pkg::year_len(yr_q);
	assign yfit = acc_q < g2l_pkg::ACC_W'(ylen);

	assign mbit_idx = 5'd16 - 5'(mon_q);
	always_comb begin
		if (phase_q) begin
			mlen = info_q[16] ? 5'd30 : 5'd29;
		end else begin
			mlen = info_q[mbit_idx] ? 5'd30 : 5'd29;
		end
	end
	assign mfit = acc_q < g2l_pkg::ACC_W'(mlen);
	// last month unless a leap twelfth month still follows
	assign mlast = (mon_q == 4'd12) && (phase_q || info_q[3:0] != 4'd12);

	assign out_free = !out_valid_q || rsp.ready;
	assign emit = out_free
		&& (ctl.op == g2l_pkg::OP_EMIT_OK || ctl.op == g2l_pkg::OP_EMIT_BAD);

	assign req.ready = (ctl.op == g2l_pkg::OP_LOAD);
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	assign flags.in_valid = req.valid;
	assign flags.bad = bad;
	assign flags.early = acc_q < g2l_pkg::ACC_W'(g2l_pkg::EPOCH_SKIP);
	assign flags.yfit = yfit;
	assign flags.ylast = (yr_q == g2l_pkg::YIDX_W'(g2l_pkg::YEAR_COUNT - 1));
	assign flags.yend = (yr_q == g2l_pkg::YIDX_W'(g2l_pkg::YEAR_COUNT));
	assign flags.mfit = mfit;
	assign flags.mlast = mlast;
	assign flags.hit = hit_q;
	assign flags.out_free = out_free;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			g2l_pkg::OP_LOAD: begin
				if (req.valid) begin
					gy_q <= req.data.greg_year;
					gm_q <= req.data.greg_month;
					gd_q <= req.data.greg_day;
				end
			end
			g2l_pkg::OP_YMUL: begin
				acc_q <= g2l_pkg::ACC_W'(yoff) * 17'd365;
				yr_q <= '0;
			end
			g2l_pkg::OP_DAYS: begin
				acc_q <= day_sum;
			end
			g2l_pkg::OP_EPOCH: begin
				acc_q <= acc_q - g2l_pkg::ACC_W'(g2l_pkg::EPOCH_SKIP);
			end
			g2l_pkg::OP_YSTEP: begin
				if (!yfit) begin
					acc_q <= acc_q - g2l_pkg::ACC_W'(ylen);
					yr_q <= yr_q + 8'd1;
				end
			end
			g2l_pkg::OP_MINIT: begin
				info_q <= g2l_pkg::year_desc(yr_q);
				mon_q <= 4'd1;
				phase_q <= 1'b0;
			end
			g2l_pkg::OP_MSTEP: begin
				hit_q <= mfit;
				if (!mfit) begin
					acc_q <= acc_q - g2l_pkg::ACC_W'(mlen);
					// the leap month follows the ordinary month of the same number
					if (!phase_q && info_q[3:0] == mon_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						mon_q <= mon_q + 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (ctl.op == g2l_pkg::OP_EMIT_OK) begin
				out_q.date_valid <= 1'b1;
				out_q.lunar_year <= 12'(g2l_pkg::FIRST_YEAR) + 12'(yr_q);
				out_q.lunar_month <= mon_q;
				out_q.lunar_day <= acc_q[4:0] + 5'd1;
				out_q.leap_month_flag <= phase_q;
			end else begin
				out_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_ok_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.date_valid) |-> (rsp.data.lunar_month >= 4'd1
		&& rsp.data.lunar_month <= 4'd12 && rsp.data.lunar_day >= 5'd1
		&& rsp.data.lunar_day <= 5'd30))
		else $error("converted date out of range");

	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.date_valid) |-> (rsp.data.lunar_year == 12'd0
		&& rsp.data.lunar_month == 4'd0 && rsp.data.lunar_day == 5'd0
		&& !rsp.data.leap_month_flag))
		else $error("rejected date carries nonzero fields");

	a_yr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == g2l_pkg::OP_YSTEP |-> yr_q < g2l_pkg::YIDX_W'(g2l_pkg::YEAR_COUNT))
		else $error("year walk ran past the table");
`endif

endmodule
`default_nettype wire

>>> design/gregorian_to_lunar_date_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake      word
// req      in   valid/ready    greg_year, greg_month, greg_day
// rsp      out  valid/ready    date_valid, lunar_year, lunar_month, lunar_day,
//                              leap_month_flag
//
// one date at a time; a bad field goes to the reject step after the check, a date before
// the epoch after the epoch step; a late date walks the year-length table one lunar
// year at a time, then the month walk one lunar month (plus the leap month) at a time
// reset clears the sequencer to its idle step and empties the output register
// a waiting result holds in the output register while the next word is accepted;
// a new result waits in its final step until the register is free
module gregorian_to_lunar_date_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	g2l_in_if.sink     req,
	g2l_out_if.source  rsp
);

	g2l_pkg::ctl_t   ctl;
	g2l_pkg::flags_t flags;

	g2l_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	g2l_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.flags  (flags),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
